// ===== hw/rtl/bitmap_free_run_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap free-run allocator
// Clocked concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FREE_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_FREE_RUN_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every edge outside reset
`define BFRA_ASSERT(label, clock, reset, expr, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define BFRA_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

`else

`define BFRA_ASSERT(label, clock, reset, expr, msg)
`define BFRA_ASSERT_IMPL(label, clock, reset, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared sizes, codes, types and helpers of the bitmap free-run allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfra_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = MAX_SLOTS / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(WORD_BITS);
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int WHOLE_W    = COUNT_W - WORD_IDX_W;

  localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(1024);

  // APB register map
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ELEMENT_COUNT = PADDR_W'(0);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_INDEX  = 2'd1,
    STATUS_BAD_LENGTH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIT,
    S_FIND,
    S_INIT,
    S_RESP
  } state_t;

  // per-word scan outcome
  typedef struct packed {
    logic                  hit;
    logic [WORD_IDX_W-1:0] pos;
    logic [COUNT_W-1:0]    carry;
  } scan_t;

  // Bits of word w that lie below count n: all, a low part, or none.
  function automatic logic [WORD_BITS-1:0] fill_word(input logic [ADDR_W-1:0]  w,
                                                     input logic [COUNT_W-1:0] n);
    logic [WHOLE_W-1:0]    whole;
    logic [WORD_IDX_W-1:0] rem;
    logic [WORD_BITS-1:0]  m;
    whole = n[COUNT_W-1:WORD_IDX_W];
    rem   = n[WORD_IDX_W-1:0];
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (WORD_IDX_W'(b) < rem);
    end
    if (WHOLE_W'(w) < whole) begin
      fill_word = '1;
    end else if (WHOLE_W'(w) == whole) begin
      fill_word = m;
    end else begin
      fill_word = '0;
    end
  endfunction

endpackage

// ===== hw/rtl/bfra_ram.sv =====
// ----------------------------------------------------------------------------
// bfra_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bfra_word_scan.sv =====
// ----------------------------------------------------------------------------
// bfra_word_scan
// Finds the first position in one bitmap word where a free run of the
// requested length ends, given the run carried in from lower words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfra_word_scan (
  input  logic [bfra_pkg::WORD_BITS-1:0] word,
  input  logic [bfra_pkg::COUNT_W-1:0]   carry_in,
  input  logic [bfra_pkg::COUNT_W-1:0]   run_length,
  output bfra_pkg::scan_t                result
);
  import bfra_pkg::*;

  localparam int LEVELS = WORD_IDX_W;

  // hz: a used slot at or below b; pz: highest such slot
  logic                  hz [LEVELS+1][WORD_BITS];
  logic [WORD_IDX_W-1:0] pz [LEVELS+1][WORD_BITS];
  logic [WORD_BITS-1:0]  hit;

  genvar k, b;
  generate
    for (b = 0; b < WORD_BITS; b++) begin : g_init
      assign hz[0][b] = ~word[b];
      assign pz[0][b] = WORD_IDX_W'(b);
    end
    for (k = 0; k < LEVELS; k++) begin : g_level
      for (b = 0; b < WORD_BITS; b++) begin : g_bit
        if (b >= (1 << k)) begin : g_take
          assign hz[k+1][b] = hz[k][b] | hz[k][b-(1<<k)];
          assign pz[k+1][b] = hz[k][b] ? pz[k][b] : pz[k][b-(1<<k)];
        end else begin : g_pass
          assign hz[k+1][b] = hz[k][b];
          assign pz[k+1][b] = pz[k][b];
        end
      end
    end
    for (b = 0; b < WORD_BITS; b++) begin : g_hit
      logic [COUNT_W-1:0] run_end;
      assign run_end = hz[LEVELS][b] ? (COUNT_W'(b) - COUNT_W'(pz[LEVELS][b]))
                                     : (carry_in + COUNT_W'(b + 1));
      assign hit[b] = (run_end >= run_length);
    end
  endgenerate

  // lowest ending position wins
  always_comb begin
    result.hit = |hit;
    result.pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        result.pos = WORD_IDX_W'(i);
      end
    end
    result.carry = hz[LEVELS][WORD_BITS-1]
                 ? (COUNT_W'(WORD_BITS - 1) - COUNT_W'(pz[LEVELS][WORD_BITS-1]))
                 : (carry_in + COUNT_W'(WORD_BITS));
  end

endmodule

// ===== hw/rtl/bitmap_free_run_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_free_run_allocator
// Flow: read/write fetch the addressed word first; range errors and zero-length
//   find go straight to the result; find scans to a hit or the count's last word.
// Throughput: one command at a time; the next is taken the cycle after the
//   result enters the output register, find paced by one RAM word per cycle.
// Reset: sync, active high; a clearing pass fills the RAM, in_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_free_run_allocator_macros.svh"

module bitmap_free_run_allocator (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [bfra_pkg::INDEX_W-1:0] bit_index,
  input  logic                         write_value,
  input  logic [bfra_pkg::COUNT_W-1:0] run_length,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic                         bit_value,
  output logic                         found,
  output logic [bfra_pkg::INDEX_W-1:0] region_start,
  // APB config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfra_pkg::PADDR_W-1:0] paddr,
  input  logic [bfra_pkg::PDATA_W-1:0] pwdata,
  output logic [bfra_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bfra_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);

  // --------------------------------------------------------------------------
  // Config register. Count above MAX_SLOTS behaves as MAX_SLOTS.
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] element_count;
  logic [COUNT_W-1:0] live_count;
  logic [ADDR_W-1:0]  last_word;
  logic [COUNT_W-1:0] count_m1;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= RESET_COUNT;
    end else if (psel && penable && pwrite && pready && (paddr == REG_ELEMENT_COUNT)) begin
      element_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ELEMENT_COUNT) begin
      prdata = PDATA_W'(element_count);
    end
  end

  assign live_count = (element_count > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                            : element_count;
  // word holding the last slot in use (only meaningful for a nonzero count)
  assign count_m1  = live_count - COUNT_W'(1);
  assign last_word = count_m1[WORD_IDX_W +: ADDR_W];

  // --------------------------------------------------------------------------
  // Bitmap RAM: one word per WORD_BITS slots, 1 = free.
  // --------------------------------------------------------------------------
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bfra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Run search over the word just read. Slots at or above the count are
  // masked off so a stale free bit past the count never extends a run.
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] scan_word;
  scan_t                scan;

  logic [COUNT_W-1:0] carry, carry_next;
  logic [COUNT_W-1:0] len, len_next;
  logic [ADDR_W-1:0]  word_ptr, word_ptr_next;

  assign scan_word = ram_rdata & fill_word(word_ptr, live_count);

  bfra_word_scan u_scan (
    .word       (scan_word),
    .carry_in   (carry),
    .run_length (len),
    .result     (scan)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t               state, state_next;
  cmd_t                 cmd, cmd_next;
  logic [INDEX_W-1:0]   idx, idx_next;
  logic                 wval, wval_next;
  status_t              res_status, res_status_next;
  logic                 res_bit, res_bit_next;
  logic                 res_found, res_found_next;
  logic [INDEX_W-1:0]   res_start, res_start_next;
  logic [COUNT_W-1:0]   start_sum;
  logic                 out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_RESP) && (!out_valid || out_ready);

  // run ends at (word_ptr, pos); start = end + 1 - len
  assign start_sum = COUNT_W'({word_ptr, scan.pos}) + COUNT_W'(1) - len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      word_ptr <= '0;
    end else begin
      state    <= state_next;
      word_ptr <= word_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    idx        <= idx_next;
    wval       <= wval_next;
    len        <= len_next;
    carry      <= carry_next;
    res_status <= res_status_next;
    res_bit    <= res_bit_next;
    res_found  <= res_found_next;
    res_start  <= res_start_next;
  end

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    idx_next        = idx;
    wval_next       = wval;
    len_next        = len;
    carry_next      = carry;
    word_ptr_next   = word_ptr;
    res_status_next = res_status;
    res_bit_next    = res_bit;
    res_found_next  = res_found;
    res_start_next  = res_start;

    ram_raddr = word_ptr;
    ram_we    = 1'b0;
    ram_waddr = word_ptr;
    ram_wdata = fill_word(word_ptr, live_count);

    unique case (state)
      // post-reset fill: the user must keep the count at its reset value here; the block does not enforce it
      S_CLEAR: begin
        ram_we = 1'b1;
        if (word_ptr == LAST_ADDR) begin
          word_ptr_next = '0;
          state_next    = S_IDLE;
        end else begin
          word_ptr_next = word_ptr + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        ram_raddr = bit_index[WORD_IDX_W +: ADDR_W];
        if (in_valid) begin
          cmd_next        = cmd_t'(command);
          idx_next        = bit_index;
          wval_next       = write_value;
          len_next        = run_length;
          carry_next      = '0;
          word_ptr_next   = '0;
          res_status_next = STATUS_OK;
          res_bit_next    = 1'b0;
          res_found_next  = 1'b0;
          res_start_next  = '0;
          unique case (cmd_t'(command))
            CMD_READ, CMD_WRITE: begin
              if (COUNT_W'(bit_index) >= live_count) begin
                res_status_next = STATUS_BAD_INDEX;
                state_next      = S_RESP;
              end else begin
                state_next = S_BIT;
              end
            end
            CMD_FIND: begin
              ram_raddr = '0;
              if (run_length > live_count) begin
                res_status_next = STATUS_BAD_LENGTH;
                state_next      = S_RESP;
              end else if (run_length == '0) begin
                res_found_next = 1'b1;
                state_next     = S_RESP;
              end else begin
                state_next = S_FIND;
              end
            end
            CMD_INIT: begin
              state_next = (live_count == '0) ? S_RESP : S_INIT;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      // word holding the addressed slot is on the read port
      S_BIT: begin
        if (cmd == CMD_READ) begin
          res_bit_next = ram_rdata[idx[WORD_IDX_W-1:0]];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx[WORD_IDX_W +: ADDR_W];
          ram_wdata = ram_rdata;
          ram_wdata[idx[WORD_IDX_W-1:0]] = wval;
        end
        state_next = S_RESP;
      end

      // word word_ptr on the read port, next word already requested
      S_FIND: begin
        ram_raddr = word_ptr + ADDR_W'(1);
        if (scan.hit) begin
          res_found_next = 1'b1;
          res_start_next = start_sum[INDEX_W-1:0];
          state_next     = S_RESP;
        end else if (word_ptr == last_word) begin
          state_next = S_RESP;
        end else begin
          word_ptr_next = word_ptr + ADDR_W'(1);
          carry_next    = scan.carry;
        end
      end

      // one word per cycle; words past the count keep their contents
      S_INIT: begin
        ram_we = 1'b1;
        if (word_ptr == last_word) begin
          state_next = S_RESP;
        end else begin
          word_ptr_next = word_ptr + ADDR_W'(1);
        end
      end

      // wait for the output register to free up
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  status_t            out_status;
  logic               out_bit;
  logic               out_found;
  logic [INDEX_W-1:0] out_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_bit    <= res_bit;
      out_found  <= res_found;
      out_start  <= res_start;
    end
  end

  assign status       = out_status;
  assign bit_value    = out_bit;
  assign found        = out_found;
  assign region_start = out_start;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `BFRA_ASSERT_IMPL(a_found_ok, clk, rst, out_valid && found, (status == STATUS_OK) && !bit_value, "found result carries error or bit")
  `BFRA_ASSERT_IMPL(a_bit_ok, clk, rst, out_valid && bit_value, (status == STATUS_OK) && !found, "read bit on error or find result")
  `BFRA_ASSERT_IMPL(a_no_write_in_find, clk, rst, state == S_FIND, !ram_we, "bitmap written during run search")

endmodule

// ===== tb/sv/tb_bitmap_free_run_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_free_run_allocator
// Self-checking bench for the free-slot bitmap allocator: directed corner
// cases, then mixed read/write/find/init traffic under several slot counts
// and back-pressure mixes, each result checked against an in-bench copy
// of the bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_free_run_allocator;
  import bfra_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           command;
  logic [INDEX_W-1:0]   bit_index;
  logic                 write_value;
  logic [COUNT_W-1:0]   run_length;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic                 bit_value;
  logic                 found;
  logic [INDEX_W-1:0]   region_start;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_free_run_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .bit_index    (bit_index),
    .write_value  (write_value),
    .run_length   (run_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .bit_value    (bit_value),
    .found        (found),
    .region_start (region_start),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow bitmap and slot count; mirrors what the block should hold
  // --------------------------------------------------------------------------
  typedef struct {
    status_t            status;
    logic               bit_value;
    logic               found;
    logic [INDEX_W-1:0] region_start;
  } alloc_result_t;

  logic [WORD_BITS-1:0] shadow_map [WORD_COUNT];
  logic [COUNT_W-1:0]   shadow_count;
  alloc_result_t        alloc_results_due [$];

  // idle odds in percent, changed between phases
  int send_idle_pct;
  int recv_idle_pct;

  int error_count;
  int words_sent;
  int results_checked;
  int runs_found;
  int settings_applied;

  // count above the bitmap size behaves as the full bitmap
  function automatic int slots_in_use();
    return (shadow_count > COUNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(shadow_count);
  endfunction

  // every slot below the count goes free; a partly used last word has its
  // upper bits cleared; words wholly past the count are left alone
  function automatic void mark_slots_free();
    int n;
    int whole;
    int rem;
    n     = slots_in_use();
    whole = n / WORD_BITS;
    rem   = n % WORD_BITS;
    for (int w = 0; w < whole; w++) shadow_map[w] = '1;
    if (rem != 0 && whole < WORD_COUNT) begin
      shadow_map[whole] = '0;
      for (int b = 0; b < rem; b++) shadow_map[whole][b] = 1'b1;
    end
  endfunction

  // Apply one command to the shadow state and return the result it owes.
  function automatic alloc_result_t compute_alloc_result(input cmd_t c,
                                                         input logic [INDEX_W-1:0] idx,
                                                         input logic v,
                                                         input logic [COUNT_W-1:0] len);
    alloc_result_t r;
    int n;
    int run;
    int last;
    int i;
    r.status       = STATUS_OK;
    r.bit_value    = 1'b0;
    r.found        = 1'b0;
    r.region_start = '0;
    n = slots_in_use();
    case (c)
      CMD_READ, CMD_WRITE: begin
        if (int'(idx) >= n) begin
          r.status = STATUS_BAD_INDEX;
        end else if (c == CMD_READ) begin
          r.bit_value = shadow_map[idx / WORD_BITS][idx % WORD_BITS];
        end else begin
          shadow_map[idx / WORD_BITS][idx % WORD_BITS] = v;
        end
      end
      CMD_FIND: begin
        if (int'(len) > n) begin
          r.status = STATUS_BAD_LENGTH;
        end else begin
          // first-fit walk from slot 0; stops as soon as the run is long enough
          run  = 0;
          last = 0;
          i    = 0;
          while (run < int'(len) && i < n) begin
            if (shadow_map[i / WORD_BITS][i % WORD_BITS]) begin
              run++;
              last = i;
            end else begin
              run = 0;
            end
            i++;
          end
          if (run == int'(len)) begin
            r.found        = 1'b1;
            r.region_start = (len == 0) ? '0 : INDEX_W'(last + 1 - int'(len));
          end
        end
      end
      default: mark_slots_free();
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Command side: one word per call, random gap before valid goes up.
  // Valid is only dropped inside the gap, so back-to-back words never see
  // a low/high pair in the same step.
  // --------------------------------------------------------------------------
  task automatic send_word(input cmd_t c, input logic [INDEX_W-1:0] idx,
                           input logic v, input logic [COUNT_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= c;
    bit_index   <= idx;
    write_value <= v;
    run_length  <= len;
    do @(posedge clk); while (!in_ready);
    alloc_results_due.push_back(compute_alloc_result(c, idx, v, len));
    words_sent++;
  endtask

  // Drop valid and let every owed result come back, plus a short settle.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (alloc_results_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // APB write of the slot count, then read it back.
  task automatic set_element_count(input logic [COUNT_W-1:0] value);
    wait_for_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_ELEMENT_COUNT;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_count = value;
    settings_applied++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== value) begin
      $display("%0t element_count readback: expected %0d actual %0d",
               $time, value, prdata[COUNT_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls on out_ready, field-by-field compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t %s: expected %0d actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (alloc_results_due.size() == 0) begin
        $display("%0t unexpected result: expected none actual status %0d found %0d",
                 $time, status, found);
        error_count++;
      end else begin
        want = alloc_results_due.pop_front();
        check_field("status", int'(want.status), int'(status));
        check_field("bit_value", int'(want.bit_value), int'(bit_value));
        check_field("found", int'(want.found), int'(found));
        check_field("region_start", int'(want.region_start), int'(region_start));
        results_checked++;
        if (want.found) runs_found++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // full bitmap free out of reset; oversize length is rejected
  task automatic test_reset_state();
    send_word(CMD_READ, 10'd0, 1'b0, 11'd0);
    send_word(CMD_READ, 10'd1023, 1'b0, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1024);
    send_word(CMD_FIND, 10'd1023, 1'b1, 11'd2047);
  endtask

  // punch holes at both ends, then look for runs around them
  task automatic test_bit_access();
    send_word(CMD_WRITE, 10'd1023, 1'b0, 11'd0);
    send_word(CMD_READ, 10'd1023, 1'b0, 11'd0);
    send_word(CMD_WRITE, 10'd0, 1'b0, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd0);     // zero length hits at 0
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1023);  // no run that long
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1022);  // lands just past the hole
  endtask

  // init with a count inside word 1: upper bits of that word clear,
  // words past the count keep old contents
  task automatic test_init_partial();
    set_element_count(11'd40);
    send_word(CMD_INIT, 10'd0, 1'b0, 11'd0);
    send_word(CMD_READ, 10'd39, 1'b0, 11'd0);
    send_word(CMD_READ, 10'd40, 1'b0, 11'd0);    // out of range at count 40
    set_element_count(11'd1024);
    send_word(CMD_READ, 10'd40, 1'b0, 11'd0);
    send_word(CMD_READ, 10'd1023, 1'b0, 11'd0);
  endtask

  // zero count, clamped oversize count, single slot
  task automatic test_count_extremes();
    set_element_count(11'd0);
    send_word(CMD_READ, 10'd0, 1'b0, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1);
    set_element_count(11'd2047);
    send_word(CMD_INIT, 10'd0, 1'b0, 11'd0);
    send_word(CMD_READ, 10'd1023, 1'b0, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1024);
    set_element_count(11'd1);
    send_word(CMD_WRITE, 10'd0, 1'b0, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1);
    send_word(CMD_WRITE, 10'd0, 1'b1, 11'd0);
    send_word(CMD_FIND, 10'd0, 1'b0, 11'd1);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: writes lean toward used so the map fragments, finds
  // mostly ask for short runs, occasional init refills the map
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input logic [COUNT_W-1:0] count, input int words);
    int n;
    int pick;
    int sel;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] len;
    set_element_count(count);
    n = slots_in_use();
    for (int k = 0; k < words; k++) begin
      pick = $urandom_range(99);
      if (n > 0 && $urandom_range(99) < 85) idx = INDEX_W'($urandom_range(n - 1));
      else idx = INDEX_W'($urandom_range(1023));
      sel = $urandom_range(99);
      if (sel < 70)      len = COUNT_W'($urandom_range((n < 24) ? n : 24, 1));
      else if (sel < 85) len = COUNT_W'($urandom_range(n));
      else if (sel < 95) len = COUNT_W'((n < 2047) ? $urandom_range(2047, n + 1) : n);
      else               len = '0;
      if (pick < 35)      send_word(CMD_WRITE, idx, ($urandom_range(99) < 40), len);
      else if (pick < 55) send_word(CMD_READ, idx, 1'($urandom_range(1)), len);
      else if (pick < 96) send_word(CMD_FIND, idx, 1'($urandom_range(1)), len);
      else                send_word(CMD_INIT, idx, 1'($urandom_range(1)), len);
    end
  endtask

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    command     <= CMD_READ;
    bit_index   <= '0;
    write_value <= 1'b0;
    run_length  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    error_count      = 0;
    words_sent       = 0;
    results_checked  = 0;
    runs_found       = 0;
    settings_applied = 0;
    send_idle_pct    = 29;
    recv_idle_pct    = 57;
    // shadow comes out of reset like the block: count 1024, all free
    for (int w = 0; w < WORD_COUNT; w++) shadow_map[w] = '0;
    shadow_count = RESET_COUNT;
    mark_slots_free();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_bit_access();
    test_init_partial();
    test_count_extremes();

    // sender sparse, receiver stalls often
    test_random_traffic(11'd100, 296);
    test_random_traffic(11'd1024, 296);
    // the other way round
    send_idle_pct = 57;
    recv_idle_pct = 29;
    test_random_traffic(11'd1, 296);
    test_random_traffic(11'd517, 296);
    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(11'd2047, 296);
    test_random_traffic(11'd64, 296);

    wait_for_results();
    if (alloc_results_due.size() != 0) begin
      $display("%0t missing results: expected %0d more actual 0",
               $time, alloc_results_due.size());
      error_count++;
    end

    $display("Sent %0d command words under %0d slot-count settings (0, 1, partial, full, clamped).",
             words_sent, settings_applied);
    $display("Checked %0d results; %0d finds located a free run.", results_checked, runs_found);
    if (error_count == 0) begin
      $display("bitmap_free_run_allocator verification clean");
    end else begin
      $display("bitmap_free_run_allocator verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("bitmap_free_run_allocator verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bfra_pkg.sv
hw/rtl/bfra_ram.sv
hw/rtl/bfra_word_scan.sv
hw/rtl/bitmap_free_run_allocator.sv
tb/sv/tb_bitmap_free_run_allocator.sv
